/* src/sdf_pkg.sv */
// sdf_pkg: shared types and constants of the signed decimal formatter
// no dependencies; imported by sdf_bcd_conv and signed_decimal_formatter_unit
package sdf_pkg;

    // decimal digit slots, enough for the magnitude of a 64-bit value
    localparam int DIGIT_SLOTS = 20;
    localparam int DIGIT_IDX_W = 5;
    localparam int COUNT_W     = 5;

    // packed bcd digits, digit 0 is the least significant
    typedef logic [DIGIT_SLOTS-1:0][3:0] t_digits;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    // sign mode codes
    localparam logic [1:0] SIGN_MODE_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MODE_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MODE_SPACE = 2'd2;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CONV   = 5'b00010,
        S_SIZE   = 5'b00100,
        S_SIGN   = 5'b01000,
        S_DIGITS = 5'b10000
    } t_state;

endpackage

/* src/sdf_bcd_conv.sv */
// sdf_bcd_conv: iterative binary to bcd converter, shift-and-add-three, one bit per cycle
// depends on sdf_pkg
module sdf_bcd_conv
    import sdf_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_done,
    output t_digits               o_digits
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]    r_bin;
    t_digits                  r_bcd;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_run;
    logic                     r_done;
    t_digits                  n_adj;
    logic [DIGIT_SLOTS*4-1:0] n_adj_bits;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            n_adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    // adjusted digits as one flat word for the shift
    assign n_adj_bits = n_adj;

    // control: run until every value bit is shifted in, pulse done after the last shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: shift the next binary bit into the bcd word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
            r_cnt <= CNT_W'(VALUE_BITS - 1);
        end else if (r_run) begin
            r_bcd <= {n_adj_bits[DIGIT_SLOTS*4-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_bcd;

endmodule

/* src/signed_decimal_formatter_unit.sv */
// signed_decimal_formatter_unit: printf style signed decimal conversion, top level
// depends on sdf_pkg and sdf_bcd_conv
//
// An item is taken when start is high and busy is low. The magnitude goes
// through a bit-serial bcd converter, the S_SIZE state sizes the digit
// field, then the text leaves one character per cycle, sign first, on
// o_character with o_valid high for one cycle and o_last on the final one.
// The converter shifts in one bit per cycle. An item whose text is empty
// gives no strobe. The receiver cannot stall: every character is
// presented exactly once and must be taken in that cycle.
module signed_decimal_formatter_unit
    import sdf_pkg::*;
#(
    parameter int MAX_CHARS  = 63,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic signed [6:0]            i_precision,
    input  logic [5:0]                   i_field_width,
    input  logic                         i_zero_pad,
    input  logic [1:0]                   i_sign_mode,
    output logic                         o_valid,
    output logic [7:0]                   o_character,
    output logic                         o_last
);

    t_state                r_state;
    t_state                n_state;
    logic [VALUE_BITS-1:0] r_mag_in;
    logic                  r_mag_zero;
    logic [6:0]            r_prec;
    logic [5:0]            r_width;
    logic                  r_zp;
    logic [7:0]            r_sign_char;
    logic                  r_has_sign;
    logic [COUNT_W-1:0]    r_dc;
    logic [6:0]            r_pos;
    logic                  r_valid;
    logic [7:0]            r_char;
    logic                  r_last;

    logic                  accept;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  conv_done;
    t_digits               digits;
    logic [COUNT_W-1:0]    n_dc;
    logic [6:0]            n_len;
    logic [6:0]            n_room;
    logic [6:0]            n_field;
    logic [7:0]            digit_char;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign in_neg = i_value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~i_value + 1'b1) : i_value;

    // magnitude to bcd converter
    sdf_bcd_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_mag    (r_mag_in),
        .o_done   (conv_done),
        .o_digits (digits)
    );

    // latch the item; the converter loads the magnitude at the same edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag_zero <= (i_value == '0);
            r_prec     <= i_precision;
            r_width    <= i_field_width;
            r_zp       <= i_zero_pad;
            if (in_neg) begin
                r_sign_char <= CHAR_MINUS;
                r_has_sign  <= 1'b1;
            end else if (i_sign_mode == SIGN_MODE_PLUS) begin
                r_sign_char <= CHAR_PLUS;
                r_has_sign  <= 1'b1;
            end else if (i_sign_mode == SIGN_MODE_SPACE) begin
                r_sign_char <= CHAR_SPACE;
                r_has_sign  <= 1'b1;
            end else begin
                r_sign_char <= CHAR_NONE;
                r_has_sign  <= 1'b0;
            end
        end
    end

    // the load reaches the converter in the same edge as the latch above
    always_comb begin
        r_mag_in = in_mag;
    end

    // digit count: highest nonzero digit, zero still has one digit
    always_comb begin
        n_dc = COUNT_W'(1);
        for (int i = 1; i < DIGIT_SLOTS; i++) begin
            if (digits[i] != 4'd0) begin
                n_dc = COUNT_W'(i + 1);
            end
        end
    end

    // digit field length from precision, zero fill and the width, capped to the room beside the sign
    always_comb begin
        n_len = {2'b00, n_dc};
        if (r_prec == 7'd0 && r_mag_zero) begin
            n_len = 7'd0;
        end else if (!r_prec[6] && r_prec >= {2'b00, n_dc}) begin
            n_len = r_prec;
        end else if (r_prec[6] && r_zp) begin
            if (r_has_sign) begin
                if (r_width != 6'd0 && ({1'b0, r_width} - 7'd1) >= {2'b00, n_dc}) begin
                    n_len = {1'b0, r_width} - 7'd1;
                end
            end else if ({1'b0, r_width} >= {2'b00, n_dc}) begin
                n_len = {1'b0, r_width};
            end
        end
        n_room  = 7'(MAX_CHARS) - {6'd0, r_has_sign};
        n_field = (n_len < n_room) ? n_len : n_room;
    end

    // character of the digit at the current position, fill zero above the digits
    always_comb begin
        if (r_pos < {2'b00, r_dc}) begin
            digit_char = CHAR_ZERO | {4'd0, digits[r_pos[DIGIT_IDX_W-1:0]]};
        end else begin
            digit_char = CHAR_ZERO;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CONV;
            end
            S_CONV: begin
                if (conv_done) n_state = S_SIZE;
            end
            S_SIZE: begin
                if (r_has_sign) begin
                    n_state = S_SIGN;
                end else if (n_field != 7'd0) begin
                    n_state = S_DIGITS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SIGN: begin
                n_state = (r_pos == 7'h7F) ? S_IDLE : S_DIGITS;
            end
            S_DIGITS: begin
                if (r_pos == 7'd0) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, position counter and output transfer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            unique case (r_state)
                S_SIZE: begin
                    r_dc  <= n_dc;
                    r_pos <= n_field - 7'd1;
                end
                S_SIGN: begin
                    r_valid <= 1'b1;
                    r_char  <= r_sign_char;
                    r_last  <= (r_pos == 7'h7F);
                end
                S_DIGITS: begin
                    r_valid <= 1'b1;
                    r_char  <= digit_char;
                    r_last  <= (r_pos == 7'd0);
                    r_pos   <= r_pos - 7'd1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule
